// File: src/chrelay_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chrelay_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int SCALE_W    = 14;
  localparam int VOLT_W     = 24;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SCALE      = cfg_idx_t'(0);
  localparam cfg_idx_t REG_OFFSET     = cfg_idx_t'(1);
  localparam cfg_idx_t REG_ALPHA      = cfg_idx_t'(2);
  localparam cfg_idx_t REG_DROP       = cfg_idx_t'(3);
  localparam cfg_idx_t REG_DISCONNECT = cfg_idx_t'(4);
  localparam cfg_idx_t REG_START_MIN  = cfg_idx_t'(5);
  localparam cfg_idx_t REG_START_MAX  = cfg_idx_t'(6);
  localparam cfg_idx_t REG_STOP       = cfg_idx_t'(7);

  localparam logic [SCALE_W-1:0]    RST_SCALE      = 14'd8183;
  localparam logic [CFG_DATA_W-1:0] RST_OFFSET     = 16'd10240;
  localparam logic [CFG_DATA_W-1:0] RST_ALPHA      = 16'd1966;
  localparam logic [CFG_DATA_W-1:0] RST_DROP       = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] RST_DISCONNECT = 16'd6000;
  localparam logic [CFG_DATA_W-1:0] RST_START_MIN  = 16'd19000;
  localparam logic [CFG_DATA_W-1:0] RST_START_MAX  = 16'd27500;
  localparam logic [CFG_DATA_W-1:0] RST_STOP       = 16'd29500;

  localparam logic [VOLT_W-1:0] VOLT_MAX = {VOLT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_FILTER,
    ST_UPDATE,
    ST_RELAY
  } state_t;

  typedef struct packed {
    logic capture;
    logic clamp_en;
    logic filter_en;
    logic update_en;
    logic commit;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// File: src/chrelay_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module chrelay_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire logic                  req_type,
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output chrelay_pkg::ctrl_cmd_t     cmd
);

  chrelay_pkg::state_t state;
  chrelay_pkg::state_t state_next;
  logic                rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= chrelay_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      chrelay_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = req_type ? chrelay_pkg::ST_RELAY : chrelay_pkg::ST_CLAMP;
        end
      end
      chrelay_pkg::ST_CLAMP: begin
        cmd.clamp_en = 1'b1;
        state_next   = chrelay_pkg::ST_FILTER;
      end
      chrelay_pkg::ST_FILTER: begin
        cmd.filter_en = 1'b1;
        state_next    = chrelay_pkg::ST_UPDATE;
      end
      chrelay_pkg::ST_UPDATE: begin
        cmd.update_en = 1'b1;
        state_next    = chrelay_pkg::ST_RELAY;
      end
      chrelay_pkg::ST_RELAY: begin
        // wait for the result register to free up
        if (!rsp_valid || !rsp_stall) begin
          cmd.commit = 1'b1;
          state_next = chrelay_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = chrelay_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule

`default_nettype wire

// File: src/chrelay_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module chrelay_dp #(
  parameter int ADC_BITS = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire chrelay_pkg::ctrl_cmd_t               cmd,
  input  wire logic                                 req_type,
  input  wire logic [ADC_BITS-1:0]                  adc_sample,
  input  wire logic                                 command_on,
  input  wire logic                                 cfg_wr_en,
  input  wire chrelay_pkg::cfg_idx_t                cfg_index,
  input  wire logic [chrelay_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                      relay_on,
  output logic                                      relay_changed,
  output logic                                      disconnected,
  output logic [chrelay_pkg::VOLT_W-1:0]            filtered_mv_q8
);

  localparam int VW     = chrelay_pkg::VOLT_W;
  localparam int DW     = chrelay_pkg::CFG_DATA_W;
  localparam int PROD_W = ADC_BITS + chrelay_pkg::SCALE_W;
  localparam int SUM_W  = (PROD_W + 1 > VW + 1) ? PROD_W + 1 : VW + 1;
  localparam int DIFF_W = VW + 1;
  localparam int MUL_W  = DIFF_W + DW + 1;
  localparam int ACC_W  = MUL_W + 1;

  logic [chrelay_pkg::SCALE_W-1:0] scale_mv_q8;
  logic [DW-1:0] offset_mv_q8;
  logic [DW-1:0] alpha_q16;
  logic [DW-1:0] drop_mv;
  logic [DW-1:0] disconnect_mv;
  logic [DW-1:0] start_min_mv;
  logic [DW-1:0] start_max_mv;
  logic [DW-1:0] stop_mv;

  logic                     item_cmd;
  logic                     item_on;
  logic [PROD_W-1:0]        scaled;
  logic [VW-1:0]            vin;
  logic signed [MUL_W-1:0]  step;
  logic                     load;
  logic [VW-1:0]            smoothed;
  logic                     first_pending;
  logic                     relay_state;
  logic                     disconnect_flag;

  logic [SUM_W-1:0]         sum;
  logic [VW-1:0]            vin_next;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        drop_sum;
  logic signed [ACC_W-1:0]  acc;
  logic                     relay_next;
  logic                     flag_next;
  logic                     changed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mv_q8   <= chrelay_pkg::RST_SCALE;
      offset_mv_q8  <= chrelay_pkg::RST_OFFSET;
      alpha_q16     <= chrelay_pkg::RST_ALPHA;
      drop_mv       <= chrelay_pkg::RST_DROP;
      disconnect_mv <= chrelay_pkg::RST_DISCONNECT;
      start_min_mv  <= chrelay_pkg::RST_START_MIN;
      start_max_mv  <= chrelay_pkg::RST_START_MAX;
      stop_mv       <= chrelay_pkg::RST_STOP;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        chrelay_pkg::REG_SCALE:      scale_mv_q8   <= cfg_data[chrelay_pkg::SCALE_W-1:0];
        chrelay_pkg::REG_OFFSET:     offset_mv_q8  <= cfg_data;
        chrelay_pkg::REG_ALPHA:      alpha_q16     <= cfg_data;
        chrelay_pkg::REG_DROP:       drop_mv       <= cfg_data;
        chrelay_pkg::REG_DISCONNECT: disconnect_mv <= cfg_data;
        chrelay_pkg::REG_START_MIN:  start_min_mv  <= cfg_data;
        chrelay_pkg::REG_START_MAX:  start_max_mv  <= cfg_data;
        chrelay_pkg::REG_STOP:       stop_mv       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // raw * scale + offset, saturated
  always_comb begin
    sum = SUM_W'(scaled) + SUM_W'(offset_mv_q8);
    if (sum[SUM_W-1:VW] != '0) begin
      vin_next = chrelay_pkg::VOLT_MAX;
    end else begin
      vin_next = sum[VW-1:0];
    end
  end

  // s + alpha * (vin - s) is the same average as alpha*vin + (1 - alpha)*s
  assign diff     = $signed({1'b0, vin}) - $signed({1'b0, smoothed});
  assign drop_sum = {1'b0, vin} + DIFF_W'({drop_mv, 8'h00});
  assign acc      = $signed({{(ACC_W-VW-16){1'b0}}, smoothed, 16'h0000})
                    + ACC_W'(step) + ACC_W'(32768);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_cmd <= req_type;
      item_on  <= command_on;
      scaled   <= PROD_W'(adc_sample) * PROD_W'(scale_mv_q8);
    end
    if (cmd.clamp_en) begin
      vin <= vin_next;
    end
    if (cmd.filter_en) begin
      step <= $signed({1'b0, alpha_q16}) * diff;
      load <= first_pending || (drop_sum < {1'b0, smoothed});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed      <= '0;
      first_pending <= 1'b1;
    end else if (cmd.update_en) begin
      first_pending <= 1'b0;
      if (load) begin
        smoothed <= vin;
      end else begin
        smoothed <= acc[VW+15:16];
      end
    end
  end

  always_comb begin
    relay_next   = relay_state;
    flag_next    = disconnect_flag;
    changed_next = 1'b0;
    if (item_cmd) begin
      relay_next   = item_on;
      changed_next = relay_state != item_on;
    end else if (smoothed <= {disconnect_mv, 8'h00}) begin
      if (!disconnect_flag) begin
        flag_next    = 1'b1;
        relay_next   = 1'b0;
        changed_next = relay_state;
      end
    end else begin
      flag_next = 1'b0;
      if (relay_state) begin
        if (smoothed >= {stop_mv, 8'h00}) begin
          relay_next   = 1'b0;
          changed_next = 1'b1;
        end
      end else if (smoothed >= {start_min_mv, 8'h00} &&
                   smoothed <= {start_max_mv, 8'h00}) begin
        relay_next   = 1'b1;
        changed_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_state     <= 1'b0;
      disconnect_flag <= 1'b0;
    end else if (cmd.commit) begin
      relay_state     <= relay_next;
      disconnect_flag <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      relay_on       <= relay_next;
      relay_changed  <= changed_next;
      disconnected   <= flag_next;
      filtered_mv_q8 <= smoothed;
    end
  end

endmodule

`default_nettype wire

// File: src/charge_relay_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Charge relay controller. Each request transaction carries either a converter
// sample (req_type 0) or a remote relay command (req_type 1) and yields exactly one
// response transaction with the relay level, a changed flag, the disconnect flag and
// the filtered voltage in millivolts with eight fractional bits. A sample's result is
// registered after the clamp, filter, update and relay states; a command goes from
// idle straight to the relay state. The controller walks one item at a time through
// scale, saturate, average multiply, filter update and relay decision; the relay
// decision waits while the previous result is still stalled. A new request is taken
// as soon as the previous item's result sits in the output register, even if that
// result is still stalled. Registers are written through cfg_wr_en, cfg_index and
// cfg_data; the user must do so only while idle, which the block itself does not
// enforce. Indexes above seven are ignored.
module charge_relay_controller #(
  parameter int ADC_BITS = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  output logic                                     req_stall,
  input  wire logic                                req_type,
  input  wire logic [ADC_BITS-1:0]                 adc_sample,
  input  wire logic                                command_on,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_stall,
  output logic                                     relay_on,
  output logic                                     relay_changed,
  output logic                                     disconnected,
  output logic [chrelay_pkg::VOLT_W-1:0]           filtered_mv_q8,
  input  wire logic                                cfg_wr_en,
  input  wire chrelay_pkg::cfg_idx_t               cfg_index,
  input  wire logic [chrelay_pkg::CFG_DATA_W-1:0]  cfg_data
);

  chrelay_pkg::ctrl_cmd_t cmd;

  chrelay_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  chrelay_dp #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .req_type       (req_type),
    .adc_sample     (adc_sample),
    .command_on     (command_on),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .relay_on       (relay_on),
    .relay_changed  (relay_changed),
    .disconnected   (disconnected),
    .filtered_mv_q8 (filtered_mv_q8)
  );

endmodule

`default_nettype wire

// File: src/chrelay_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module chrelay_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      req_valid,
  input wire logic                      req_stall,
  input wire logic                      rsp_valid,
  input wire logic                      rsp_stall,
  input wire logic                      relay_on,
  input wire logic                      relay_changed,
  input wire logic                      disconnected,
  input wire logic [chrelay_pkg::VOLT_W-1:0] filtered_mv_q8
);

  logic       req_acc;
  logic       rsp_acc;
  logic       last_relay;
  logic [1:0] open_cnt;

  assign req_acc = req_valid && !req_stall;
  assign rsp_acc = rsp_valid && !rsp_stall;

  // relay level and outstanding transactions as seen on the ports
  always_ff @(posedge clk) begin
    if (rst) begin
      last_relay <= 1'b0;
      open_cnt   <= 2'd0;
    end else begin
      if (rsp_acc) begin
        last_relay <= relay_on;
      end
      open_cnt <= open_cnt + 2'(req_acc) - 2'(rsp_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_acc |-> (relay_changed == (relay_on != last_relay)))
    else $error("relay_changed disagrees with relay level");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (open_cnt != 2'd0))
    else $error("response without a request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    open_cnt != 2'd3)
    else $error("too many open transactions");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(relay_on) && $stable(relay_changed)
      && $stable(disconnected) && $stable(filtered_mv_q8))
    else $error("stalled response changed");

endmodule

bind charge_relay_controller chrelay_checker u_chrelay_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req_valid),
  .req_stall      (req_stall),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .relay_on       (relay_on),
  .relay_changed  (relay_changed),
  .disconnected   (disconnected),
  .filtered_mv_q8 (filtered_mv_q8)
);

`default_nettype wire

// File: tb/charge_relay_controller_tb.sv
`timescale 1ns / 1ps

module charge_relay_controller_tb;

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_COMMAND = 1'b1;

  localparam chrelay_pkg::cfg_idx_t REG_UNUSED_LO = chrelay_pkg::cfg_idx_t'(8);
  localparam chrelay_pkg::cfg_idx_t REG_UNUSED_HI = chrelay_pkg::cfg_idx_t'(15);

  typedef struct packed {
    logic                          relay_on;
    logic                          relay_changed;
    logic                          disconnected;
    logic [chrelay_pkg::VOLT_W-1:0] filtered_mv_q8;
  } relay_result_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              req_valid = 1'b0;
  logic                              req_stall;
  logic                              req_type = REQ_SAMPLE;
  logic [9:0]                        adc_sample = '0;
  logic                              command_on = 1'b0;
  logic                              rsp_valid;
  logic                              rsp_stall = 1'b0;
  logic                              relay_on;
  logic                              relay_changed;
  logic                              disconnected;
  logic [chrelay_pkg::VOLT_W-1:0]     filtered_mv_q8;
  logic                              cfg_wr_en = 1'b0;
  chrelay_pkg::cfg_idx_t             cfg_index = chrelay_pkg::REG_SCALE;
  logic [chrelay_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // register shadow
  logic [chrelay_pkg::SCALE_W-1:0]    cfg_scale;
  logic [chrelay_pkg::CFG_DATA_W-1:0] cfg_offset;
  logic [chrelay_pkg::CFG_DATA_W-1:0] cfg_alpha;
  logic [chrelay_pkg::CFG_DATA_W-1:0] cfg_drop;
  logic [chrelay_pkg::CFG_DATA_W-1:0] cfg_disconnect;
  logic [chrelay_pkg::CFG_DATA_W-1:0] cfg_start_min;
  logic [chrelay_pkg::CFG_DATA_W-1:0] cfg_start_max;
  logic [chrelay_pkg::CFG_DATA_W-1:0] cfg_stop;

  // filter and relay state
  logic [chrelay_pkg::VOLT_W-1:0] avg_q8;
  logic                          first_pending;
  logic                          relay_level;
  logic                          line_down;

  relay_result_t expected_results[$];
  int            mismatch_count = 0;
  int            send_idle_pct = 0;
  int            rsp_stall_pct = 0;

  charge_relay_controller dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_type       (req_type),
    .adc_sample     (adc_sample),
    .command_on     (command_on),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .relay_on       (relay_on),
    .relay_changed  (relay_changed),
    .disconnected   (disconnected),
    .filtered_mv_q8 (filtered_mv_q8),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  task automatic report_mismatch(input string what,
                                 input logic [chrelay_pkg::VOLT_W-1:0] got,
                                 input logic [chrelay_pkg::VOLT_W-1:0] want);
    $display("[%0t] %s: got 0x%06h expected 0x%06h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    relay_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("response with no transaction pending", filtered_mv_q8, '0);
      end else begin
        want = expected_results.pop_front();
        if (relay_on !== want.relay_on)
          report_mismatch("relay_on", chrelay_pkg::VOLT_W'(relay_on),
                          chrelay_pkg::VOLT_W'(want.relay_on));
        if (relay_changed !== want.relay_changed)
          report_mismatch("relay_changed", chrelay_pkg::VOLT_W'(relay_changed),
                          chrelay_pkg::VOLT_W'(want.relay_changed));
        if (disconnected !== want.disconnected)
          report_mismatch("disconnected", chrelay_pkg::VOLT_W'(disconnected),
                          chrelay_pkg::VOLT_W'(want.disconnected));
        if (filtered_mv_q8 !== want.filtered_mv_q8)
          report_mismatch("filtered_mv_q8", filtered_mv_q8, want.filtered_mv_q8);
      end
    end
  end

  task automatic reset_relay_model();
    cfg_scale      = chrelay_pkg::RST_SCALE;
    cfg_offset     = chrelay_pkg::RST_OFFSET;
    cfg_alpha      = chrelay_pkg::RST_ALPHA;
    cfg_drop       = chrelay_pkg::RST_DROP;
    cfg_disconnect = chrelay_pkg::RST_DISCONNECT;
    cfg_start_min  = chrelay_pkg::RST_START_MIN;
    cfg_start_max  = chrelay_pkg::RST_START_MAX;
    cfg_stop       = chrelay_pkg::RST_STOP;
    avg_q8         = '0;
    first_pending  = 1'b1;
    relay_level    = 1'b0;
    line_down      = 1'b0;
  endtask

  task automatic switch_relay(input logic level, inout logic changed);
    if (relay_level != level) begin
      relay_level = level;
      changed = 1'b1;
    end
  endtask

  task automatic predict_relay_result(input logic kind, input logic [9:0] sample,
                                      input logic cmd);
    logic [63:0]   vin;
    logic [63:0]   acc;
    logic          changed;
    relay_result_t r;
    changed = 1'b0;
    if (kind == REQ_COMMAND) begin
      switch_relay(cmd, changed);
    end else begin
      vin = 64'(sample) * 64'(cfg_scale) + 64'(cfg_offset);
      if (vin > 64'(chrelay_pkg::VOLT_MAX))
        vin = 64'(chrelay_pkg::VOLT_MAX);
      if (first_pending) begin
        avg_q8 = vin[chrelay_pkg::VOLT_W-1:0];
        first_pending = 1'b0;
      end else if (vin + (64'(cfg_drop) << 8) < 64'(avg_q8)) begin
        avg_q8 = vin[chrelay_pkg::VOLT_W-1:0];
      end else begin
        acc = 64'(cfg_alpha) * vin + (64'd65536 - 64'(cfg_alpha)) * 64'(avg_q8) + 64'd32768;
        avg_q8 = acc[chrelay_pkg::VOLT_W+15:16];
      end
      if (64'(avg_q8) <= (64'(cfg_disconnect) << 8)) begin
        if (!line_down) begin
          line_down = 1'b1;
          switch_relay(1'b0, changed);
        end
      end else begin
        line_down = 1'b0;
        if (relay_level) begin
          if (64'(avg_q8) >= (64'(cfg_stop) << 8))
            switch_relay(1'b0, changed);
        end else if (64'(avg_q8) >= (64'(cfg_start_min) << 8) &&
                     64'(avg_q8) <= (64'(cfg_start_max) << 8)) begin
          switch_relay(1'b1, changed);
        end
      end
    end
    r.relay_on       = relay_level;
    r.relay_changed  = changed;
    r.disconnected   = line_down;
    r.filtered_mv_q8 = avg_q8;
    expected_results.push_back(r);
  endtask

  task automatic send_item(input logic kind, input logic [9:0] sample, input logic cmd);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid  <= 1'b1;
    req_type   <= kind;
    adc_sample <= sample;
    command_on <= cmd;
    @(posedge clk);
    while (req_stall)
      @(posedge clk);
    predict_relay_result(kind, sample, cmd);
  endtask

  task automatic send_sample(input logic [9:0] sample);
    send_item(REQ_SAMPLE, sample, 1'($urandom));
  endtask

  task automatic send_command(input logic cmd);
    send_item(REQ_COMMAND, 10'($urandom), cmd);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input chrelay_pkg::cfg_idx_t idx,
                           input logic [chrelay_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      chrelay_pkg::REG_SCALE:      cfg_scale      = data[chrelay_pkg::SCALE_W-1:0];
      chrelay_pkg::REG_OFFSET:     cfg_offset     = data;
      chrelay_pkg::REG_ALPHA:      cfg_alpha      = data;
      chrelay_pkg::REG_DROP:       cfg_drop       = data;
      chrelay_pkg::REG_DISCONNECT: cfg_disconnect = data;
      chrelay_pkg::REG_START_MIN:  cfg_start_min  = data;
      chrelay_pkg::REG_START_MAX:  cfg_start_max  = data;
      chrelay_pkg::REG_STOP:       cfg_stop       = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_defaults();
    write_reg(chrelay_pkg::REG_SCALE, chrelay_pkg::CFG_DATA_W'(chrelay_pkg::RST_SCALE));
    write_reg(chrelay_pkg::REG_OFFSET, chrelay_pkg::RST_OFFSET);
    write_reg(chrelay_pkg::REG_ALPHA, chrelay_pkg::RST_ALPHA);
    write_reg(chrelay_pkg::REG_DROP, chrelay_pkg::RST_DROP);
    write_reg(chrelay_pkg::REG_DISCONNECT, chrelay_pkg::RST_DISCONNECT);
    write_reg(chrelay_pkg::REG_START_MIN, chrelay_pkg::RST_START_MIN);
    write_reg(chrelay_pkg::REG_START_MAX, chrelay_pkg::RST_START_MAX);
    write_reg(chrelay_pkg::REG_STOP, chrelay_pkg::RST_STOP);
  endtask

  // thresholds placed so the filter actually walks through every relay region
  task automatic write_tuned_setting();
    int lo;
    int hi;
    lo = $urandom_range(24000, 12000);
    hi = lo + $urandom_range(10000, 1000);
    write_reg(chrelay_pkg::REG_SCALE,
              chrelay_pkg::CFG_DATA_W'($urandom_range(10000, 6000)));
    write_reg(chrelay_pkg::REG_OFFSET, chrelay_pkg::CFG_DATA_W'($urandom_range(20000)));
    write_reg(chrelay_pkg::REG_ALPHA,
              chrelay_pkg::CFG_DATA_W'($urandom_range(20000, 500)));
    write_reg(chrelay_pkg::REG_DROP, chrelay_pkg::CFG_DATA_W'($urandom_range(5000, 500)));
    write_reg(chrelay_pkg::REG_DISCONNECT,
              chrelay_pkg::CFG_DATA_W'($urandom_range(10000, 2000)));
    write_reg(chrelay_pkg::REG_START_MIN, chrelay_pkg::CFG_DATA_W'(lo));
    write_reg(chrelay_pkg::REG_START_MAX, chrelay_pkg::CFG_DATA_W'(hi));
    write_reg(chrelay_pkg::REG_STOP,
              chrelay_pkg::CFG_DATA_W'(hi + $urandom_range(4000, 500)));
  endtask

  task automatic write_wild_setting();
    write_reg(chrelay_pkg::REG_SCALE, chrelay_pkg::CFG_DATA_W'($urandom));
    write_reg(chrelay_pkg::REG_OFFSET, chrelay_pkg::CFG_DATA_W'($urandom));
    write_reg(chrelay_pkg::REG_ALPHA, chrelay_pkg::CFG_DATA_W'($urandom));
    write_reg(chrelay_pkg::REG_DROP, chrelay_pkg::CFG_DATA_W'($urandom));
    write_reg(chrelay_pkg::REG_DISCONNECT, chrelay_pkg::CFG_DATA_W'($urandom));
    write_reg(chrelay_pkg::REG_START_MIN, chrelay_pkg::CFG_DATA_W'($urandom));
    write_reg(chrelay_pkg::REG_START_MAX, chrelay_pkg::CFG_DATA_W'($urandom));
    write_reg(chrelay_pkg::REG_STOP, chrelay_pkg::CFG_DATA_W'($urandom));
  endtask

  task automatic test_commands_without_sample();
    send_command(1'b0);
    send_command(1'b1);
    send_command(1'b1);
    send_command(1'b0);
  endtask

  task automatic test_filter_relay_path();
    send_sample(10'd1023);
    send_sample(10'd700);
    send_sample(10'd1023);
    send_sample(10'd900);
    send_sample(10'd0);
    send_sample(10'd0);
    send_command(1'b1);
    send_sample(10'd0);
    send_sample(10'd1023);
  endtask

  task automatic test_scaling_saturation();
    wait_idle();
    write_reg(chrelay_pkg::REG_SCALE, chrelay_pkg::CFG_DATA_W'(16383));
    write_reg(chrelay_pkg::REG_OFFSET, chrelay_pkg::CFG_DATA_W'(65535));
    send_sample(10'd1023);
    send_sample(10'd512);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(chrelay_pkg::REG_ALPHA, '0);
    write_reg(chrelay_pkg::REG_DISCONNECT, chrelay_pkg::CFG_DATA_W'(65535));
    send_sample(10'd1023);
    send_sample(10'd1000);
    wait_idle();
    write_reg(chrelay_pkg::REG_ALPHA, chrelay_pkg::CFG_DATA_W'(65535));
    write_reg(chrelay_pkg::REG_DROP, '0);
    write_reg(chrelay_pkg::REG_DISCONNECT, '0);
    write_reg(chrelay_pkg::REG_OFFSET, '0);
    write_reg(chrelay_pkg::REG_START_MIN, chrelay_pkg::CFG_DATA_W'(40000));
    write_reg(chrelay_pkg::REG_START_MAX, chrelay_pkg::CFG_DATA_W'(30000));
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd800);
    wait_idle();
    write_reg(chrelay_pkg::REG_DROP, chrelay_pkg::CFG_DATA_W'(65535));
    write_reg(chrelay_pkg::REG_START_MIN, '0);
    write_reg(chrelay_pkg::REG_START_MAX, chrelay_pkg::CFG_DATA_W'(65535));
    write_reg(chrelay_pkg::REG_STOP, '0);
    // writes to unmapped indexes must not disturb anything
    write_reg(REG_UNUSED_LO, '0);
    write_reg(REG_UNUSED_HI, chrelay_pkg::CFG_DATA_W'(65535));
    send_sample(10'd1);
    send_sample(10'd600);
    wait_idle();
    write_reg(chrelay_pkg::REG_STOP, chrelay_pkg::CFG_DATA_W'(65535));
    send_sample(10'd600);
    send_command(1'b1);
    send_sample(10'd1023);
  endtask

  // samples follow a drifting level with jitter, sudden jumps, noise and commands
  task automatic run_level_walk(input int count);
    int level;
    int pick;
    level = $urandom_range(1023);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_command(1'($urandom));
      end else if (pick < 12) begin
        send_sample(10'($urandom));
      end else begin
        if (pick < 16)
          level = $urandom_range(1023);
        else
          level = level + $urandom_range(16) - 8;
        if (level < 0)
          level = 0;
        if (level > 1023)
          level = 1023;
        send_sample(10'(level));
      end
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12;
          rsp_stall_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          rsp_stall_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          rsp_stall_pct = 0;
        end
      endcase
      for (int setting = 0; setting < 2; setting++) begin
        wait_idle();
        if (phase == 0 && setting == 0)
          write_defaults();
        else if (setting == 0 || phase == 0)
          write_tuned_setting();
        else
          write_wild_setting();
        run_level_walk(300);
      end
    end
  endtask

  initial begin
    reset_relay_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 12;
    rsp_stall_pct = 80;
    test_commands_without_sample();
    test_filter_relay_path();
    test_scaling_saturation();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d responses outstanding", expected_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
